// ===== hdl/ddo_pkg.sv =====
// Package: types, constants and tables for the differential drive odometry unit.
package ddo_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW = 5;
  localparam logic [31:0] MptReset = 32'd1629346;
  localparam logic [31:0] HgReset = 32'd3694980000;
  localparam logic [31:0] CordicGain = 32'd652032874;

  localparam logic [0:0] CFG_MPT = 1'b0;
  localparam logic [0:0] CFG_HG = 1'b1;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mul_l;
    logic mul_r;
    logic mul_turn;
    logic mul_turn_hi;
    logic cor_start_mid;
    logic cor_step;
    logic mul_x;
    logic mul_y;
    logic upd_pose;
    logic cor_start_half;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic cor_last;
  } dp_sts_t;

  function automatic logic [31:0] atan_lut(input logic [StepW-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001; default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ddo_datapath.sv =====
// Datapath: wheel deltas, turn product, shared CORDIC and pose accumulators.
module ddo_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  ddo_pkg::dp_cmd_t   cmd,
  output ddo_pkg::dp_sts_t   sts,
  input  ddo_pkg::in_item_t  in_item,
  input  logic [31:0]        mpt,
  input  logic [31:0]        hg,
  output ddo_pkg::out_item_t res
);

  logic [31:0] last_l_r, last_r_r, last_l_nxt, last_r_nxt;
  logic signed [31:0] dlt_l_r, dlt_r_r;
  logic signed [47:0] dl_r, dr_r;
  logic [31:0] turn_r, half_r;
  logic [48:0] tlo_r;
  logic signed [31:0] acc_x_r, acc_y_r;
  logic [31:0] acc_h_r;
  logic signed [31:0] fwd_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [ddo_pkg::StepW-1:0] step_r;
  logic signed [63:0] px_r, py_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic [48:0] tsum;
  logic signed [48:0] dsum, ddiff;
  logic signed [48:0] fwd_full;
  logic [31:0] mid_ang, cang;
  logic        cflip;
  logic signed [33:0] xs, ys;
  logic [31:0] at;

  assign last_l_nxt = in_item.left_count;
  assign last_r_nxt = in_item.right_count;
  assign dsum = 49'(dl_r) + 49'(dr_r);
  assign ddiff = 49'(dr_r) - 49'(dl_r);
  assign fwd_full = dsum >>> 1;

  // multiplier operand select; the turn product is taken modulo 2^49: low 32 bits of the difference, then the high 17
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_l) begin
      mul_a = 33'(dlt_l_r);
      mul_b = {1'b0, mpt};
    end else if (cmd.mul_r) begin
      mul_a = 33'(dlt_r_r);
      mul_b = {1'b0, mpt};
    end else if (cmd.mul_turn) begin
      mul_a = {1'b0, ddiff[31:0]};
      mul_b = {1'b0, hg};
    end else if (cmd.mul_turn_hi) begin
      mul_a = {16'd0, ddiff[48:32]};
      mul_b = {16'd0, hg[16:0]};
    end else if (cmd.mul_x) begin
      mul_a = 33'(fwd_r);
      mul_b = cx_r[32:0];
    end else begin
      mul_a = 33'(fwd_r);
      mul_b = cy_r[32:0];
    end
  end

  assign mul_p = mul_a * mul_b;
  assign tsum = tlo_r + {mul_p[16:0], 32'd0};

  assign mid_ang = cmd.cor_start_mid ? acc_h_r + half_r : {1'b0, acc_h_r[31:1]};
  assign cflip = mid_ang[31] ^ mid_ang[30];
  assign cang = cflip ? {~mid_ang[31], mid_ang[30:0]} : mid_ang;
  assign xs = cx_r >>> step_r;
  assign ys = cy_r >>> step_r;
  assign at = ddo_pkg::atan_lut(step_r);
  assign sts.cor_last = (step_r == ddo_pkg::StepW'(ddo_pkg::CordicSteps - 1));

  logic flip_r;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] q15(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [19:0] r;
    t = 35'(v) + 35'sd16384;
    r = 20'(t >>> 15);
    if (r > 20'sd32767) return 16'sh7FFF;
    if (r < -20'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_l_r <= '0;
      last_r_r <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_h_r <= '0;
      step_r <= '0;
    end else begin
      if (cmd.load) begin
        dlt_l_r <= $signed(last_l_nxt - last_l_r);
        dlt_r_r <= $signed(last_r_nxt - last_r_r);
        last_l_r <= last_l_nxt;
        last_r_r <= last_r_nxt;
      end
      if (cmd.mul_l) dl_r <= 48'(mul_p >>> 16);
      if (cmd.mul_r) dr_r <= 48'(mul_p >>> 16);
      if (cmd.mul_turn) begin
        tlo_r <= mul_p[48:0];
        if (fwd_full > 49'sd2147483647) fwd_r <= 32'sh7FFFFFFF;
        else if (fwd_full < -49'sd2147483648) fwd_r <= 32'sh80000000;
        else fwd_r <= fwd_full[31:0];
      end
      if (cmd.mul_turn_hi) begin
        turn_r <= tsum[47:16];
        half_r <= tsum[48:17];
      end
      if (cmd.cor_start_mid || cmd.cor_start_half) begin
        cx_r <= 34'(ddo_pkg::CordicGain);
        cy_r <= '0;
        cz_r <= 34'($signed(cang));
        flip_r <= cflip;
        step_r <= '0;
      end else if (cmd.cor_step) begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - 34'(at);
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + 34'(at);
        end
        if (sts.cor_last) begin
          if (flip_r) begin
            cx_r <= -((!cz_r[33]) ? cx_r - ys : cx_r + ys);
            cy_r <= -((!cz_r[33]) ? cy_r + xs : cy_r - xs);
          end
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
      if (cmd.mul_x) px_r <= 64'(mul_p >>> 30);
      if (cmd.mul_y) py_r <= 64'(mul_p >>> 30);
      if (cmd.upd_pose) begin
        acc_x_r <= sat32(34'(acc_x_r) + 34'(px_r));
        acc_y_r <= sat32(34'(acc_y_r) + 34'(py_r));
        acc_h_r <= acc_h_r + turn_r;
      end
      if (cmd.emit) begin
        res.pos_x <= acc_x_r;
        res.pos_y <= acc_y_r;
        res.heading <= acc_h_r;
        res.quat_z <= q15(cy_r);
        res.quat_w <= q15(cx_r);
      end
    end
  end

endmodule

// ===== hdl/ddo_ctrl.sv =====
// Controller: sequences one sample through the datapath and runs the handshake.
module ddo_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output ddo_pkg::dp_cmd_t cmd,
  input  ddo_pkg::dp_sts_t sts
);

  localparam logic [3:0] S_IDLE = 4'd0, S_ML = 4'd1, S_MR = 4'd2, S_MT = 4'd3,
                         S_C1S = 4'd4, S_C1 = 4'd5, S_MX = 4'd6, S_MY = 4'd7,
                         S_UPD = 4'd8, S_C2S = 4'd9, S_C2 = 4'd10, S_EMIT = 4'd11,
                         S_MTH = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  assign out_valid = ov_r;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ov_nxt = ov_r && out_stall;
    unique case (state_r)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_nxt = S_ML; end
      S_ML: begin cmd.mul_l = 1'b1; state_nxt = S_MR; end
      S_MR: begin cmd.mul_r = 1'b1; state_nxt = S_MT; end
      S_MT: begin cmd.mul_turn = 1'b1; state_nxt = S_MTH; end
      S_MTH: begin cmd.mul_turn_hi = 1'b1; state_nxt = S_C1S; end
      S_C1S: begin cmd.cor_start_mid = 1'b1; state_nxt = S_C1; end
      S_C1: begin cmd.cor_step = 1'b1; if (sts.cor_last) state_nxt = S_MX; end
      S_MX: begin cmd.mul_x = 1'b1; state_nxt = S_MY; end
      S_MY: begin cmd.mul_y = 1'b1; state_nxt = S_UPD; end
      S_UPD: begin cmd.upd_pose = 1'b1; state_nxt = S_C2S; end
      S_C2S: begin cmd.cor_start_half = 1'b1; state_nxt = S_C2; end
      S_C2: begin cmd.cor_step = 1'b1; if (sts.cor_last) state_nxt = S_EMIT; end
      S_EMIT: if (!ov_nxt) begin
        cmd.emit = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

// ===== hdl/diff_drive_odometry_unit.sv =====
// Top level: differential drive wheel odometry with midpoint heading.
// Usage:
//   Input channel in_valid/in_stall/in_item carries cumulative left and right
//   encoder counts. A transfer happens when in_valid is high and in_stall low.
//   Output channel out_valid/out_stall/out_item carries the pose (Q16.16 x, y),
//   the binary-angle heading and the half-angle quaternion z, w.
//   Config: cfg_we writes cfg_data to register cfg_index (0 metres_per_tick,
//   1 heading_gain); write only while idle.
// Sequence: wheel deltas, turn product, CORDIC pass at the midpoint heading,
//   x and y products, pose update, CORDIC pass at the half heading; all on
//   the one shared iterative CORDIC and a single time-shared multiplier.
// Throughput: one sample at a time; in_stall is high until the result is
//   loaded into the output register, which may still wait for out_stall.
// Reset: synchronous rst_n zeroes the pose and previous counts and loads
//   the default scale registers; the result register is empty.
// Stall: a held result keeps its payload; the unit waits before emitting the
//   next one until the output register is free.
module diff_drive_odometry_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ddo_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ddo_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [31:0] mpt_r, hg_r;
  ddo_pkg::dp_cmd_t cmd;
  ddo_pkg::dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r <= ddo_pkg::MptReset;
      hg_r <= ddo_pkg::HgReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ddo_pkg::CFG_MPT: mpt_r <= cfg_data;
        ddo_pkg::CFG_HG: hg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ddo_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  ddo_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_item, .mpt(mpt_r), .hg(hg_r), .res(out_item)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while busy");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result overwritten");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("multiple datapath commands");
`endif

endmodule

// ===== tb/diff_drive_odometry_unit_chk.sv =====
// Checker: pose predictor and result comparison for the odometry unit.
`timescale 1ns / 1ps
module diff_drive_odometry_unit_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ddo_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ddo_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import ddo_pkg::*;

  logic [31:0] mpt, hg, prev_l, prev_r, hdg;
  longint px, py;
  out_item_t pose_q[$];

  function automatic longint sat_q16(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [15:0] q30_to_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, xs, ys;
    logic flip;
    logic [31:0] a;
    x = CordicGain;
    y = 0;
    a = ang;
    flip = 1'b0;
    if (((a + 32'h40000000) & 32'h80000000) != 0) begin
      a = a ^ 32'h80000000;
      flip = 1'b1;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < CordicSteps && i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(atan_lut(i[StepW-1:0]));
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(atan_lut(i[StepW-1:0]));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic advance_pose(input in_item_t it);
    longint dlt, drt, dl, dr, fwd, c, s;
    logic [63:0] prod;
    logic [31:0] mid;
    out_item_t e;
    dlt = longint'(signed'(it.left_count - prev_l));
    drt = longint'(signed'(it.right_count - prev_r));
    prev_l = it.left_count;
    prev_r = it.right_count;
    dl = (dlt * longint'({32'd0, mpt})) >>> 16;
    dr = (drt * longint'({32'd0, mpt})) >>> 16;
    fwd = sat_q16((dl + dr) >>> 1);
    prod = 64'(dr - dl) * {32'd0, hg};
    mid = hdg + prod[48:17];
    rotate(mid, c, s);
    px = sat_q16(px + ((fwd * c) >>> 30));
    py = sat_q16(py + ((fwd * s) >>> 30));
    hdg = hdg + prod[47:16];
    rotate(hdg >> 1, c, s);
    e.pos_x = px[31:0];
    e.pos_y = py[31:0];
    e.heading = hdg;
    e.quat_z = q30_to_q15(s);
    e.quat_w = q30_to_q15(c);
    pose_q.push_back(e);
  endtask

  assign pending = pose_q.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      mpt = MptReset; hg = HgReset;
      prev_l = 0; prev_r = 0; hdg = 0; px = 0; py = 0;
      pose_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MPT) mpt = cfg_data;
        else if (cfg_index == CFG_HG) hg = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected transfer, actual %h", $time, out_item);
          fail_count++;
        end else begin
          e = pose_q.pop_front();
          if (e.pos_x !== out_item.pos_x) begin
            $display("%0t: pos_x exp %h act %h", $time, e.pos_x, out_item.pos_x);
            fail_count++;
          end
          if (e.pos_y !== out_item.pos_y) begin
            $display("%0t: pos_y exp %h act %h", $time, e.pos_y, out_item.pos_y);
            fail_count++;
          end
          if (e.heading !== out_item.heading) begin
            $display("%0t: heading exp %h act %h", $time, e.heading, out_item.heading);
            fail_count++;
          end
          if (e.quat_z !== out_item.quat_z) begin
            $display("%0t: quat_z exp %h act %h", $time, e.quat_z, out_item.quat_z);
            fail_count++;
          end
          if (e.quat_w !== out_item.quat_w) begin
            $display("%0t: quat_w exp %h act %h", $time, e.quat_w, out_item.quat_w);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) advance_pose(in_item);
    end
  end
endmodule

// ===== tb/diff_drive_odometry_unit_tb.sv =====
// Testbench top: stimulus, configuration phases and verdict for the odometry unit.
`timescale 1ns / 1ps
module diff_drive_odometry_unit_tb;
  import ddo_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_MPT;
  logic [31:0] cfg_data = '0;
  int fail_count, pending;
  logic quiet = 1'b0;
  logic hold_off = 1'b0;
  logic [31:0] cur_l = 0, cur_r = 0;
  int stall_left = 0;

  always #10 clk = ~clk;

  diff_drive_odometry_unit dut (.*);

  diff_drive_odometry_unit_chk chk (.*);

  task automatic send_counts(input logic [31:0] l, input logic [31:0] r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{left_count: l, right_count: r};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic step_by(input int dl, input int dr);
    cur_l = cur_l + dl;
    cur_r = cur_r + dr;
    send_counts(cur_l, cur_r);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] v);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_run(input int n);
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        cur_l = $urandom; cur_r = $urandom;
        send_counts(cur_l, cur_r);
      end else if (sel < 3) begin
        step_by($urandom_range(0, 20000) - 10000, $urandom_range(0, 20000) - 10000);
      end else begin
        step_by($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else out_stall <= 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, wrap, spin
    send_counts(32'h7FFFFFFF, 32'h80000000);
    send_counts(32'h80000000, 32'h7FFFFFFF);
    send_counts(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_counts(32'h00000000, 32'h00000000);
    send_counts(32'h80000000, 32'h80000000);
    send_counts(32'h7FFFFFFF, 32'h7FFFFFFF);
    cur_l = 32'h7FFFFFFF; cur_r = 32'h7FFFFFFF;
    for (int k = 0; k < 6; k++) step_by(-5000, 5000);
    for (int k = 0; k < 4; k++) step_by(30000, 30000);
    write_reg(CFG_MPT, 32'hFFFFFFFF);
    write_reg(CFG_HG, 32'hFFFFFFFF);
    for (int k = 0; k < 4; k++) step_by(2000000000, 2000000000);
    step_by(-100000, 100000);
    step_by(1, -1);
    write_reg(CFG_HG, 32'd0);
    step_by(-2000000000, 2000000000);
    write_reg(CFG_MPT, 32'd0);
    step_by(12345, -999);
    write_reg(CFG_MPT, MptReset);
    write_reg(CFG_HG, HgReset);
    random_run(300);
    hold_off <= 1'b1;
    fork
      random_run(5);
      begin
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join
    write_reg(CFG_MPT, 32'd50000000);
    write_reg(CFG_HG, 32'd400000000);
    random_run(300);
    write_reg(CFG_MPT, $urandom);
    write_reg(CFG_HG, $urandom);
    random_run(300);
    write_reg(CFG_MPT, MptReset);
    write_reg(CFG_HG, HgReset);
    quiet <= 1'b1;
    random_run(300);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("diff_drive_odometry_unit verification clean");
    else $display("diff_drive_odometry_unit verification failed");
    $finish;
  end

  initial begin
    #10000000;
    $display("diff_drive_odometry_unit verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/ddo_pkg.sv
hdl/ddo_datapath.sv
hdl/ddo_ctrl.sv
hdl/diff_drive_odometry_unit.sv
tb/diff_drive_odometry_unit_chk.sv
tb/diff_drive_odometry_unit_tb.sv
